// ===== rtl/root_descartes_quadruple_enum_defines.svh =====
// Assertion helpers for the quadruple enumerator.
// Both expect the signals clock and reset in scope.
`ifndef ROOT_DESCARTES_QUADRUPLE_ENUM_DEFINES_SVH
`define ROOT_DESCARTES_QUADRUPLE_ENUM_DEFINES_SVH

`define RDQE_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

`define RDQE_IMPLY(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

`endif

// ===== rtl/rdqe_pkg.sv =====
`default_nettype none

package rdqe_pkg;

   localparam int AW     = 7;   // a, the outer bend magnitude
   localparam int BW     = 8;   // b
   localparam int CW     = 14;  // c
   localparam int FW     = 15;  // fourth bend
   localparam int QW     = 24;  // q = b*c - a*(b+c)
   localparam int NUM_W  = 17;  // (a+b)^2
   localparam int DEN_W  = 10;  // 4*(b-a)
   localparam int STEP_W = 5;   // divider step counter
   localparam int SQ_W   = 12;  // square root of q
   localparam int GK_W   = 4;   // common power of two in the gcd
   localparam int KP_W   = 39;  // K times a

   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 48;

   localparam logic [31:0]   K_Q30    = 32'd2313592086;
   localparam int            K_FRAC   = 30;
   localparam logic [AW-1:0] MAX_BEND = 7'd100;

   // Fill quadruple (-1, 2, 2, 3), packed as on the result bus.
   localparam logic [7:0]    FILL_OUTER  = 8'hFF;
   localparam logic [BW-1:0] FILL_SECOND = 8'd2;
   localparam logic [CW-1:0] FILL_THIRD  = 14'd2;
   localparam logic [FW-1:0] FILL_FOURTH = 15'd3;
   localparam logic [RSP_TDATA_W-1:0] FILL_TDATA =
      {3'b000, FILL_FOURTH, FILL_THIRD, FILL_SECOND, FILL_OUTER};

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

`default_nettype wire

// ===== rtl/rdqe_fifo.sv =====
`default_nettype none

// Two-entry queue between the request front and the search engine.
module rdqe_fifo #(
   parameter int W = 7
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     push,
   input  wire  [W-1:0]            push_data,
   input  wire                     pop,
   output logic [W-1:0]            pop_data,
   output rdqe_pkg::q_stat_type    stat
);
   import rdqe_pkg::*;

   logic [W-1:0] mem_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         do_push, do_pop;

   assign stat       = '{full: (cnt_ff == 2'd2), empty: (cnt_ff == 2'd0)};
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign pop_data   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      cnt_in    = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/rdqe_front.sv =====
`default_nettype none

// Takes requests, drops zero counts, saturates the rest and hands them to the queue.
module rdqe_front #(
   parameter int MAX_COUNT = 64,
   parameter int CNT_W     = 7
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_tvalid,
   output logic                    req_tready,
   input  wire  [6:0]              req_count,
   input  wire rdqe_pkg::q_stat_type q_stat,
   output logic                    q_push,
   output logic [CNT_W-1:0]        q_data
);
   import rdqe_pkg::*;

   logic             stage_valid_ff, stage_valid_in;
   logic [CNT_W-1:0] stage_cnt_ff, stage_cnt_in;
   logic [6:0]       sat_count;
   logic             accept;

   assign q_push     = stage_valid_ff && !q_stat.full;
   assign q_data     = stage_cnt_ff;
   assign req_tready = !stage_valid_ff || q_push;
   assign accept     = req_tvalid && req_tready;
   assign sat_count  = (req_count > 7'(MAX_COUNT)) ? 7'(MAX_COUNT) : req_count;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_cnt_in   = stage_cnt_ff;
      if (accept) begin
         stage_valid_in = (req_count != 7'd0);
         stage_cnt_in   = CNT_W'(sat_count);
      end else if (q_push) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      stage_cnt_ff <= stage_cnt_in;
   end

endmodule

`default_nettype wire

// ===== rtl/rdqe_search.sv =====
`default_nettype none

// Search engine: walks a, b and c, with a bit-serial divider for the c bound,
// a digit-serial square root and a binary gcd, and holds the result register.
module rdqe_search #(
   parameter int CNT_W = 7
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire rdqe_pkg::q_stat_type            q_stat,
   input  wire  [CNT_W-1:0]                     q_data,
   output logic                                 q_pop,
   input  wire                                  rsp_tready,
   output logic                                 rsp_tvalid,
   output logic [rdqe_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                 rsp_tuser,
   output logic                                 rsp_tlast
);
   import rdqe_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_ASET, S_BCHK, S_DIV, S_CCHK, S_QCALC, S_SQRT, S_GCD, S_EMIT, S_FILL
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] n_ff, n_in, found_ff, found_in;
   logic [AW-1:0]    a_ff, a_in;
   logic [BW-1:0]    b_ff, b_in, bmax_ff, bmax_in;
   logic [CW-1:0]    c_ff, c_in;
   logic [NUM_W-1:0] cmax_ff, cmax_in, num_ff, num_in;
   logic [DEN_W-1:0] den_ff, den_in, rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [QW-1:0]    p1_ff, p1_in, p2_ff, p2_in, v_ff, v_in, bit_ff, bit_in;
   logic [QW:0]      r_ff, r_in;
   logic [CW-1:0]    gx_ff, gx_in, gy_ff, gy_in;
   logic [GK_W-1:0]  gk_ff, gk_in;
   logic             gph_ff, gph_in;
   logic             out_valid_ff, out_valid_in;
   logic [RSP_TDATA_W-1:0] out_data_ff, out_data_in;
   logic             out_user_ff, out_user_in, out_last_ff, out_last_in;

   logic              out_free;
   logic [CNT_W-1:0]  found_plus;
   logic              run_last;
   logic [KP_W-1:0]   kp;
   logic [8:0]        ab_sum;
   logic [17:0]       ab_sq;
   logic [BW-1:0]     ab_diff;
   logic [DEN_W:0]    rem_sh;
   logic              div_ge;
   logic [QW:0]       rb;
   logic [CW-1:0]     g_val;
   logic [15:0]       fourth;
   logic [7:0]        outer;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;
   assign rsp_tlast  = out_last_ff;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign found_plus = found_ff + 1'b1;
   assign run_last   = (found_plus == n_ff);
   assign kp         = KP_W'(K_Q30) * KP_W'(a_ff);
   assign ab_sum     = {2'b00, a_ff} + {1'b0, b_ff};
   assign ab_sq      = ab_sum * ab_sum;
   assign ab_diff    = b_ff - {1'b0, a_ff};
   assign rem_sh     = {rem_ff, num_ff[NUM_W-1]};
   assign div_ge     = rem_sh >= {1'b0, den_ff};
   assign rb         = r_ff + {1'b0, bit_ff};
   assign g_val      = (gx_ff | gy_ff) << gk_ff;
   assign outer      = 8'd0 - {1'b0, a_ff};
   assign fourth     = {8'd0, b_ff} + {2'd0, c_ff} - {9'd0, a_ff}
                       - {3'd0, r_ff[SQ_W-1:0], 1'b0};

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      found_in     = found_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      bmax_in      = bmax_ff;
      c_in         = c_ff;
      cmax_in      = cmax_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      v_in         = v_ff;
      r_in         = r_ff;
      bit_in       = bit_ff;
      gx_in        = gx_ff;
      gy_in        = gy_ff;
      gk_in        = gk_ff;
      gph_in       = gph_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_user_in  = out_user_ff;
      out_last_in  = out_last_ff;
      q_pop        = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (!q_stat.empty) begin
               q_pop    = 1'b1;
               n_in     = q_data;
               found_in = '0;
               a_in     = '0;
               state_in = S_ASET;
            end
         end
         S_ASET: begin
            if (a_ff == MAX_BEND) begin
               state_in = S_FILL;
            end else begin
               bmax_in  = kp[K_FRAC+BW-1:K_FRAC];
               b_in     = {1'b0, a_ff} + 1'b1;
               state_in = S_BCHK;
            end
         end
         S_BCHK: begin
            if (b_ff > bmax_ff) begin
               a_in     = a_ff + 1'b1;
               state_in = S_ASET;
            end else begin
               num_in   = ab_sq[NUM_W-1:0];
               den_in   = {ab_diff, 2'b00};
               rem_in   = '0;
               step_in  = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            // Restoring division, one quotient bit per cycle.
            rem_in  = div_ge ? DEN_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DEN_W-1:0];
            num_in  = {num_ff[NUM_W-2:0], div_ge};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(NUM_W - 1)) begin
               cmax_in  = {num_ff[NUM_W-2:0], div_ge};
               c_in     = {6'd0, b_ff};
               state_in = S_CCHK;
            end
         end
         S_CCHK: begin
            if ({3'd0, c_ff} > cmax_ff) begin
               b_in     = b_ff + 1'b1;
               state_in = S_BCHK;
            end else begin
               p1_in    = QW'(b_ff * c_ff);
               p2_in    = QW'(a_ff * ({7'd0, b_ff} + {1'b0, c_ff}));
               state_in = S_QCALC;
            end
         end
         S_QCALC: begin
            if (p1_ff < p2_ff) begin
               c_in     = c_ff + 1'b1;
               state_in = S_CCHK;
            end else begin
               v_in     = p1_ff - p2_ff;
               r_in     = '0;
               bit_in   = QW'(1) << (QW - 2);
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            if (bit_ff == '0) begin
               // A zero remainder means q is a perfect square.
               if (v_ff == '0) begin
                  gx_in    = {7'd0, a_ff};
                  gy_in    = {6'd0, b_ff};
                  gk_in    = '0;
                  gph_in   = 1'b0;
                  state_in = S_GCD;
               end else begin
                  c_in     = c_ff + 1'b1;
                  state_in = S_CCHK;
               end
            end else begin
               if ({1'b0, v_ff} >= rb) begin
                  v_in = v_ff - rb[QW-1:0];
                  r_in = (r_ff >> 1) + {1'b0, bit_ff};
               end else begin
                  r_in = r_ff >> 1;
               end
               bit_in = bit_ff >> 2;
            end
         end
         S_GCD: begin
            // Binary gcd: first gcd(a,b), then gcd of that with c.
            priority if (gx_ff == '0 || gy_ff == '0) begin
               if (!gph_ff) begin
                  gx_in  = g_val;
                  gy_in  = c_ff;
                  gk_in  = '0;
                  gph_in = 1'b1;
               end else if (g_val == CW'(1)) begin
                  state_in = S_EMIT;
               end else begin
                  c_in     = c_ff + 1'b1;
                  state_in = S_CCHK;
               end
            end else if (!gx_ff[0] && !gy_ff[0]) begin
               gx_in = gx_ff >> 1;
               gy_in = gy_ff >> 1;
               gk_in = gk_ff + 1'b1;
            end else if (!gx_ff[0]) begin
               gx_in = gx_ff >> 1;
            end else if (!gy_ff[0]) begin
               gy_in = gy_ff >> 1;
            end else if (gx_ff >= gy_ff) begin
               gx_in = (gx_ff - gy_ff) >> 1;
            end else begin
               gy_in = (gy_ff - gx_ff) >> 1;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_data_in  = {3'b000, fourth[FW-1:0], c_ff, b_ff, outer};
               out_user_in  = 1'b0;
               out_last_in  = run_last;
               found_in     = found_plus;
               c_in         = c_ff + 1'b1;
               state_in     = run_last ? S_IDLE : S_CCHK;
            end
         end
         S_FILL: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_data_in  = FILL_TDATA;
               out_user_in  = 1'b1;
               out_last_in  = run_last;
               found_in     = found_plus;
               if (run_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      n_ff        <= n_in;
      found_ff    <= found_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      bmax_ff     <= bmax_in;
      c_ff        <= c_in;
      cmax_ff     <= cmax_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      p1_ff       <= p1_in;
      p2_ff       <= p2_in;
      v_ff        <= v_in;
      r_ff        <= r_in;
      bit_ff      <= bit_in;
      gx_ff       <= gx_in;
      gy_ff       <= gy_in;
      gk_ff       <= gk_in;
      gph_ff      <= gph_in;
      out_data_ff <= out_data_in;
      out_user_ff <= out_user_in;
      out_last_ff <= out_last_in;
   end

endmodule

`default_nettype wire

// ===== rtl/root_descartes_quadruple_enum.sv =====
// Channel  Direction  Item
// req      in         request count (tdata[6:0])
// rsp      out        one quadruple; tuser marks a fill item, tlast ends the run
//
// Each c candidate computes its products and, where q is not negative, a square root
// over 12 digits; each b value adds the bit-serial divider that bounds c, and a kept
// candidate adds its gcd steps.
// A zero count is taken and gives nothing. Reset is synchronous and clears control.
// The front keeps taking requests into a two-entry queue while the search runs,
// and a result waiting on rsp_tready stalls only the search.
`default_nettype none
`include "root_descartes_quadruple_enum_defines.svh"

module root_descartes_quadruple_enum #(
   parameter int MAX_COUNT = 64
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire  [rdqe_pkg::REQ_TDATA_W-1:0]   req_tdata,   // [6:0] count
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   // [7:0] outer_bend, [15:8] second_bend, [29:16] third_bend, [44:30] fourth_bend
   output logic [rdqe_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                               rsp_tuser,   // [0] from_default
   output logic                               rsp_tlast
);
   import rdqe_pkg::*;

   localparam int CNT_W = $clog2(MAX_COUNT + 1);

   q_stat_type       q_stat;
   logic             q_push, q_pop;
   logic [CNT_W-1:0] q_wdata, q_rdata;

   rdqe_front #(.MAX_COUNT(MAX_COUNT), .CNT_W(CNT_W)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_count  (req_tdata[6:0]),
      .q_stat     (q_stat),
      .q_push     (q_push),
      .q_data     (q_wdata)
   );

   rdqe_fifo #(.W(CNT_W)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .stat      (q_stat)
   );

   rdqe_search #(.CNT_W(CNT_W)) u_search (
      .clock      (clock),
      .reset      (reset),
      .q_stat     (q_stat),
      .q_data     (q_rdata),
      .q_pop      (q_pop),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   `RDQE_IMPLY(a_fill_item, rsp_tvalid && rsp_tuser, rsp_tdata == FILL_TDATA, "fill item is not the default quadruple")
   `RDQE_IMPLY(a_bend_order, rsp_tvalid && !rsp_tuser, (8'd0 - rsp_tdata[7:0]) < rsp_tdata[15:8], "second bend not above the outer bend")
   `RDQE_CHECK(a_queue_state, !(q_stat.full && q_stat.empty), "queue both full and empty")

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [7:0]  outer;
      logic [7:0]  second;
      logic [13:0] third;
      logic [14:0] fourth;
      logic        fill;
      logic        last;
   } quad_type;

   localparam int QUAD_MAX = 64;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [rdqe_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [rdqe_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic rsp_tuser;
   logic rsp_tlast;

   quad_type quad_table [QUAD_MAX];
   quad_type quad_expected [$];
   logic [6:0] count_pending [$];
   int accepted_items = 0;
   int hold_at = -1;
   int mismatches = 0;
   longint cycle_no = 0;

   always #1 clock = ~clock;

   root_descartes_quadruple_enum i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   function automatic longint isqrt(longint v);
      longint r;
      longint bit_v;
      r = 0;
      bit_v = longint'(1) << 40;
      while (bit_v > v) bit_v = bit_v >> 2;
      while (bit_v != 0) begin
         if (v >= r + bit_v) begin
            v = v - (r + bit_v);
            r = (r >> 1) + bit_v;
         end else begin
            r = r >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return r;
   endfunction

   function automatic longint gcd(longint x, longint y);
      longint t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   // The search is stateless, so a run of n items is always the first n entries.
   task automatic build_quad_table();
      int found;
      longint bmax, cmax, q, s;
      found = 0;
      for (longint a = 0; a < 100 && found < QUAD_MAX; a++) begin
         bmax = (longint'(rdqe_pkg::K_Q30) * a) >> 30;
         for (longint b = a + 1; b <= bmax && found < QUAD_MAX; b++) begin
            cmax = ((a + b) * (a + b)) / (4 * (b - a));
            for (longint c = b; c <= cmax && found < QUAD_MAX; c++) begin
               q = b * c - a * (b + c);
               if (q < 0) continue;
               s = isqrt(q);
               if (s * s != q) continue;
               if (gcd(a, gcd(b, c)) > 1) continue;
               quad_table[found].outer  = 8'(-a);
               quad_table[found].second = 8'(b);
               quad_table[found].third  = 14'(c);
               quad_table[found].fourth = 15'(-a + b + c - 2 * s);
               quad_table[found].fill   = 1'b0;
               quad_table[found].last   = 1'b0;
               found++;
            end
         end
      end
      for (; found < QUAD_MAX; found++) begin
         quad_table[found] = '{8'hFF, 8'd2, 14'd2, 15'd3, 1'b1, 1'b0};
      end
   endtask

   task automatic predict_run(logic [6:0] count);
      int n;
      quad_type item;
      n = (count > QUAD_MAX) ? QUAD_MAX : count;
      for (int k = 0; k < n; k++) begin
         item = quad_table[k];
         item.last = (k == n - 1);
         quad_expected.push_back(item);
      end
   endtask

   task automatic report(string what);
      $display("error at cycle %0d: %s", cycle_no, what);
      mismatches++;
   endtask

   always @(posedge clock) cycle_no <= cycle_no + 1;

   // Request driver; no idling while requests 40 through 70 go out.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_run(req_tdata[6:0]);
            void'(count_pending.pop_front());
            accepted_items++;
         end
         if (!req_tvalid || req_tready) begin
            if (count_pending.size() == 0 ||
                (accepted_items == hold_at && quad_expected.size() != 0) ||
                ((accepted_items < 40 || accepted_items > 70) &&
                 $urandom_range(99) < 33)) begin
               req_tvalid <= 1'b0;
            end else begin
               req_tvalid <= 1'b1;
               req_tdata  <= {1'b0, count_pending[0]};
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= (cycle_no % 20000 < 4000) || ($urandom_range(99) >= 33);
         if (rsp_tvalid && rsp_tready) begin
            if (quad_expected.size() == 0) begin
               report("result item with nothing expected");
            end else begin
               if (rsp_tdata[7:0] !== quad_expected[0].outer)
                  report($sformatf("outer_bend %0h", rsp_tdata[7:0]));
               if (rsp_tdata[15:8] !== quad_expected[0].second)
                  report($sformatf("second_bend %0h", rsp_tdata[15:8]));
               if (rsp_tdata[29:16] !== quad_expected[0].third)
                  report($sformatf("third_bend %0h", rsp_tdata[29:16]));
               if (rsp_tdata[44:30] !== quad_expected[0].fourth)
                  report($sformatf("fourth_bend %0h", rsp_tdata[44:30]));
               if (rsp_tuser !== quad_expected[0].fill)
                  report("from_default differs");
               if (rsp_tlast !== quad_expected[0].last)
                  report("last differs");
               void'(quad_expected.pop_front());
            end
         end
      end
   end

   initial begin
      int pick;
      logic [6:0] directed [] = '{7'd1, 7'd64, 7'd0, 7'd65, 7'd127, 7'd2, 7'd3,
                                  7'd63, 7'd0, 7'd1, 7'd32, 7'd100, 7'd5};
      build_quad_table();
      foreach (directed[i]) count_pending.push_back(directed[i]);
      for (int i = 0; i < 127; i++) begin
         pick = $urandom_range(99);
         if (pick < 60) count_pending.push_back(7'($urandom_range(1, 8)));
         else if (pick < 85) count_pending.push_back(7'($urandom_range(1, 64)));
         else if (pick < 93) count_pending.push_back(7'($urandom_range(65, 127)));
         else count_pending.push_back(7'd0);
      end
      hold_at = 90;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      wait (count_pending.size() == 0);
      wait (quad_expected.size() == 0);
      repeat (200) @(posedge clock);
      if (mismatches == 0 && quad_expected.size() == 0) begin
         $display("root_descartes_quadruple_enum: match");
      end else begin
         $display("root_descartes_quadruple_enum: mismatch");
      end
      $finish;
   end

   // Every request asking for 64 items stays well inside this.
   initial begin
      #500ms;
      $display("root_descartes_quadruple_enum: mismatch");
      $finish;
   end

endmodule

`default_nettype wire
